### hdl/clarke_park_transform_defines.svh
// ----------------------------------------------------------------------------
// clarke_park_transform_defines
// assertion macros used by the clarke_park_transform top level
// ----------------------------------------------------------------------------
`ifndef CLARKE_PARK_TRANSFORM_DEFINES_SVH
`define CLARKE_PARK_TRANSFORM_DEFINES_SVH

// implication checked on every clock outside reset
`define CPT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cpt: implication check failed");

// condition checked at the first clock after reset release
`define CPT_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge aclk) $rose(aresetn) |-> (cons)) \
        else $error("cpt: state after reset check failed");

`endif

### hdl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// types, widths and constants of the clarke / park axis transform
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int ANGLE_WIDTH = 16;

    // sine / cosine in q1.15, range -1.0 .. +1.0 inclusive
    localparam int SIN_FRAC = 15;
    localparam int SIN_W    = SIN_FRAC + 2;
    localparam int SIN_ONE  = 1 << SIN_FRAC;

    // quarter-wave polynomial in unsigned q1.30
    localparam int POLY_FRAC = 30;
    localparam int POLY_W    = POLY_FRAC + 1;
    localparam int SIN_S_W   = POLY_W + 1;
    localparam int R_W       = ANGLE_WIDTH - 1;
    localparam int R_SH      = POLY_FRAC - (ANGLE_WIDTH - 2);
    localparam int X2_SH     = 2 * R_SH;

    localparam logic [R_W-1:0]         QUARTER     = R_W'(1) << (ANGLE_WIDTH - 2);
    localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

    localparam logic [POLY_W-1:0] C1 = POLY_W'(1686629713);
    localparam logic [POLY_W-1:0] C3 = POLY_W'(693598669);
    localparam logic [POLY_W-1:0] C5 = POLY_W'(85569306);
    localparam logic [POLY_W-1:0] C7 = POLY_W'(5026995);
    localparam logic [POLY_W-1:0] C9 = POLY_W'(172271);

    localparam int HORNER_STEPS = 4;
    localparam logic [POLY_W-1:0] HORNER_COEF [HORNER_STEPS] = '{C7, C5, C3, C1};

    // clarke beta scale, 1/sqrt3 in q0.28
    localparam int K_FRAC  = 28;
    localparam int K_W     = K_FRAC + 1;
    localparam logic signed [K_W-1:0] INV_SQRT3 = K_W'(154981283);

    localparam int SUM_W    = DATA_WIDTH + 2;
    localparam int BPROD_W  = SUM_W + K_W;
    localparam int PROD_W   = DATA_WIDTH + SIN_W;
    localparam int SAT_IN_W = DATA_WIDTH + 3;

    localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'((2 ** (DATA_WIDTH - 1)) - 1);
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = DATA_WIDTH'(SAT_HI);
    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = DATA_WIDTH'(SAT_LO);

    typedef enum logic [1:0] {
        MODE_CLARKE_PARK = 2'b00,
        MODE_PARK        = 2'b01,
        MODE_INV_PARK    = 2'b10
    } mode_t;

    typedef struct packed {
        logic [1:0]                    mode;
        logic signed [DATA_WIDTH-1:0]  in_x;
        logic signed [DATA_WIDTH-1:0]  in_y;
        logic [ANGLE_WIDTH-1:0]        angle;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  out_first;
        logic signed [DATA_WIDTH-1:0]  out_second;
        logic signed [DATA_WIDTH-1:0]  alpha_out;
        logic signed [DATA_WIDTH-1:0]  beta_out;
        logic                          saturated;
    } out_t;

    typedef struct packed {
        logic [1:0]                    mode;
        logic signed [DATA_WIDTH-1:0]  in_x;
        logic signed [DATA_WIDTH-1:0]  in_y;
        logic signed [BPROD_W-1:0]     beta_prod;
    } ctx_t;

    typedef struct packed {
        logic [R_W-1:0]     r;
        logic [POLY_W-1:0]  x2;
        logic [POLY_W-1:0]  p;
        logic               neg;
    } lane_t;

    typedef struct packed {
        lane_t  sin_l;
        lane_t  cos_l;
        ctx_t   ctx;
    } poly_t;

    typedef struct packed {
        logic signed [SIN_W-1:0]       sn;
        logic signed [SIN_W-1:0]       cs;
        logic [1:0]                    mode;
        logic signed [DATA_WIDTH-1:0]  op_x;
        logic signed [DATA_WIDTH-1:0]  op_y;
        logic signed [DATA_WIDTH-1:0]  alpha_o;
        logic signed [DATA_WIDTH-1:0]  beta_o;
        logic                          clip;
    } sine_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  value;
        logic                          clip;
    } sat_t;

    function automatic sat_t saturate(input logic signed [SAT_IN_W-1:0] v);
        sat_t res;
        if (v > SAT_HI) begin
            res.value = OUT_MAX;
            res.clip  = 1'b1;
        end else if (v < SAT_LO) begin
            res.value = OUT_MIN;
            res.clip  = 1'b1;
        end else begin
            res.value = DATA_WIDTH'(v);
            res.clip  = 1'b0;
        end
        return res;
    endfunction

endpackage

### hdl/cpt_front_cell.sv
// ----------------------------------------------------------------------------
// cpt_front_cell
// angle folding, polynomial argument squaring and clarke beta product
// ----------------------------------------------------------------------------
module cpt_front_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cpt_pkg::in_t     in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cpt_pkg::poly_t   out_data
);

    logic                                   a_valid_reg;
    logic [cpt_pkg::R_W-1:0]                a_r_sin_reg;
    logic [cpt_pkg::R_W-1:0]                a_r_cos_reg;
    logic                                   a_neg_sin_reg;
    logic                                   a_neg_cos_reg;
    logic [1:0]                             a_mode_reg;
    logic signed [cpt_pkg::DATA_WIDTH-1:0]  a_x_reg;
    logic signed [cpt_pkg::DATA_WIDTH-1:0]  a_y_reg;
    logic signed [cpt_pkg::SUM_W-1:0]       a_sum_reg;
    logic                                   a_ready;

    logic [cpt_pkg::ANGLE_WIDTH-1:0]        ang_cos;
    logic [cpt_pkg::R_W-1:0]                r_sin_next;
    logic [cpt_pkg::R_W-1:0]                r_cos_next;
    logic signed [cpt_pkg::SUM_W-1:0]       sum_next;

    logic                                   b_valid_reg;
    cpt_pkg::poly_t                         b_data_reg;
    cpt_pkg::poly_t                         b_data_next;
    logic                                   b_ready;
    logic [2*cpt_pkg::R_W-1:0]              rr_sin;
    logic [2*cpt_pkg::R_W-1:0]              rr_cos;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    // fold both angles into the first quadrant
    always_comb begin
        ang_cos    = in_data.angle + cpt_pkg::ANG_QUARTER;
        r_sin_next = {1'b0, in_data.angle[cpt_pkg::ANGLE_WIDTH-3:0]};
        r_cos_next = {1'b0, ang_cos[cpt_pkg::ANGLE_WIDTH-3:0]};
        if (in_data.angle[cpt_pkg::ANGLE_WIDTH-2]) begin
            r_sin_next = cpt_pkg::QUARTER - r_sin_next;
        end
        if (ang_cos[cpt_pkg::ANGLE_WIDTH-2]) begin
            r_cos_next = cpt_pkg::QUARTER - r_cos_next;
        end
        sum_next = cpt_pkg::SUM_W'(in_data.in_x) + (cpt_pkg::SUM_W'(in_data.in_y) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_r_sin_reg   <= r_sin_next;
            a_r_cos_reg   <= r_cos_next;
            a_neg_sin_reg <= in_data.angle[cpt_pkg::ANGLE_WIDTH-1];
            a_neg_cos_reg <= ang_cos[cpt_pkg::ANGLE_WIDTH-1];
            a_mode_reg    <= in_data.mode;
            a_x_reg       <= in_data.in_x;
            a_y_reg       <= in_data.in_y;
            a_sum_reg     <= sum_next;
        end
    end

    // x2 = (x * x) >> 30 with x = r scaled to q30
    always_comb begin
        rr_sin = (2*cpt_pkg::R_W)'(a_r_sin_reg) * (2*cpt_pkg::R_W)'(a_r_sin_reg);
        rr_cos = (2*cpt_pkg::R_W)'(a_r_cos_reg) * (2*cpt_pkg::R_W)'(a_r_cos_reg);

        b_data_next.sin_l.r   = a_r_sin_reg;
        b_data_next.sin_l.x2  = cpt_pkg::POLY_W'((64'(rr_sin) << cpt_pkg::X2_SH)
                                                 >> cpt_pkg::POLY_FRAC);
        b_data_next.sin_l.p   = cpt_pkg::C9;
        b_data_next.sin_l.neg = a_neg_sin_reg;

        b_data_next.cos_l.r   = a_r_cos_reg;
        b_data_next.cos_l.x2  = cpt_pkg::POLY_W'((64'(rr_cos) << cpt_pkg::X2_SH)
                                                 >> cpt_pkg::POLY_FRAC);
        b_data_next.cos_l.p   = cpt_pkg::C9;
        b_data_next.cos_l.neg = a_neg_cos_reg;

        b_data_next.ctx.mode      = a_mode_reg;
        b_data_next.ctx.in_x      = a_x_reg;
        b_data_next.ctx.in_y      = a_y_reg;
        b_data_next.ctx.beta_prod = cpt_pkg::BPROD_W'(a_sum_reg)
                                  * cpt_pkg::BPROD_W'(cpt_pkg::INV_SQRT3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

### hdl/cpt_horner_cell.sv
// ----------------------------------------------------------------------------
// cpt_horner_cell
// one horner step of the quarter-wave polynomial for sine and cosine lanes
// ----------------------------------------------------------------------------
module cpt_horner_cell #(
    parameter logic [cpt_pkg::POLY_W-1:0] COEF = '0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cpt_pkg::poly_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cpt_pkg::poly_t   out_data
);

    logic                           valid_reg;
    cpt_pkg::poly_t                 data_reg;
    cpt_pkg::poly_t                 data_next;
    logic [2*cpt_pkg::POLY_W-1:0]   prod_sin;
    logic [2*cpt_pkg::POLY_W-1:0]   prod_cos;

    assign in_ready = !valid_reg || out_ready;

    // p = coef - ((x2 * p) >> 30)
    always_comb begin
        prod_sin = (2*cpt_pkg::POLY_W)'(in_data.sin_l.x2)
                 * (2*cpt_pkg::POLY_W)'(in_data.sin_l.p);
        prod_cos = (2*cpt_pkg::POLY_W)'(in_data.cos_l.x2)
                 * (2*cpt_pkg::POLY_W)'(in_data.cos_l.p);
        data_next         = in_data;
        data_next.sin_l.p = COEF - cpt_pkg::POLY_W'(prod_sin >> cpt_pkg::POLY_FRAC);
        data_next.cos_l.p = COEF - cpt_pkg::POLY_W'(prod_cos >> cpt_pkg::POLY_FRAC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hdl/cpt_back_cell.sv
// ----------------------------------------------------------------------------
// cpt_back_cell
// final polynomial product, sine / cosine rounding and clarke beta finish
// ----------------------------------------------------------------------------
module cpt_back_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cpt_pkg::poly_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cpt_pkg::sine_t   out_data
);

    logic                               c_valid_reg;
    logic [cpt_pkg::SIN_S_W-1:0]        c_s_sin_reg;
    logic [cpt_pkg::SIN_S_W-1:0]        c_s_cos_reg;
    logic                               c_neg_sin_reg;
    logic                               c_neg_cos_reg;
    cpt_pkg::ctx_t                      c_ctx_reg;
    logic                               c_ready;
    logic [cpt_pkg::POLY_W-1:0]         x_sin;
    logic [cpt_pkg::POLY_W-1:0]         x_cos;
    logic [2*cpt_pkg::POLY_W-1:0]       prod_sin;
    logic [2*cpt_pkg::POLY_W-1:0]       prod_cos;

    logic                               d_valid_reg;
    cpt_pkg::sine_t                     d_data_reg;
    cpt_pkg::sine_t                     d_data_next;
    logic                               d_ready;
    logic [cpt_pkg::SIN_S_W:0]          t_sin;
    logic [cpt_pkg::SIN_S_W:0]          t_cos;
    logic [cpt_pkg::SIN_W:0]            v_sin;
    logic [cpt_pkg::SIN_W:0]            v_cos;
    logic [cpt_pkg::SIN_W-1:0]          mag_sin;
    logic [cpt_pkg::SIN_W-1:0]          mag_cos;
    logic signed [cpt_pkg::BPROD_W-1:0] beta_rnd;
    cpt_pkg::sat_t                      beta_sat;

    assign c_ready  = !c_valid_reg || d_ready;
    assign d_ready  = !d_valid_reg || out_ready;
    assign in_ready = c_ready;

    // s = (x * p) >> 30
    always_comb begin
        x_sin    = cpt_pkg::POLY_W'(in_data.sin_l.r) << cpt_pkg::R_SH;
        x_cos    = cpt_pkg::POLY_W'(in_data.cos_l.r) << cpt_pkg::R_SH;
        prod_sin = (2*cpt_pkg::POLY_W)'(x_sin) * (2*cpt_pkg::POLY_W)'(in_data.sin_l.p);
        prod_cos = (2*cpt_pkg::POLY_W)'(x_cos) * (2*cpt_pkg::POLY_W)'(in_data.cos_l.p);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && c_ready) begin
            c_s_sin_reg   <= cpt_pkg::SIN_S_W'(prod_sin >> cpt_pkg::POLY_FRAC);
            c_s_cos_reg   <= cpt_pkg::SIN_S_W'(prod_cos >> cpt_pkg::POLY_FRAC);
            c_neg_sin_reg <= in_data.sin_l.neg;
            c_neg_cos_reg <= in_data.cos_l.neg;
            c_ctx_reg     <= in_data.ctx;
        end
    end

    always_comb begin
        t_sin   = {1'b0, c_s_sin_reg} + ((cpt_pkg::SIN_S_W+1)'(1) << (cpt_pkg::SIN_FRAC - 1));
        t_cos   = {1'b0, c_s_cos_reg} + ((cpt_pkg::SIN_S_W+1)'(1) << (cpt_pkg::SIN_FRAC - 1));
        v_sin   = t_sin[cpt_pkg::SIN_S_W:cpt_pkg::SIN_FRAC];
        v_cos   = t_cos[cpt_pkg::SIN_S_W:cpt_pkg::SIN_FRAC];
        mag_sin = (v_sin > (cpt_pkg::SIN_W+1)'(cpt_pkg::SIN_ONE)) ?
                  cpt_pkg::SIN_W'(cpt_pkg::SIN_ONE) : cpt_pkg::SIN_W'(v_sin);
        mag_cos = (v_cos > (cpt_pkg::SIN_W+1)'(cpt_pkg::SIN_ONE)) ?
                  cpt_pkg::SIN_W'(cpt_pkg::SIN_ONE) : cpt_pkg::SIN_W'(v_cos);

        beta_rnd = c_ctx_reg.beta_prod
                 + (cpt_pkg::BPROD_W'(1) <<< (cpt_pkg::K_FRAC - 1));
        beta_sat = cpt_pkg::saturate(beta_rnd[cpt_pkg::BPROD_W-1:cpt_pkg::K_FRAC]);

        d_data_next.sn   = c_neg_sin_reg ? -$signed(mag_sin) : $signed(mag_sin);
        d_data_next.cs   = c_neg_cos_reg ? -$signed(mag_cos) : $signed(mag_cos);
        d_data_next.mode = c_ctx_reg.mode;
        d_data_next.op_x = c_ctx_reg.in_x;
        if (c_ctx_reg.mode == cpt_pkg::MODE_CLARKE_PARK) begin
            d_data_next.op_y    = beta_sat.value;
            d_data_next.alpha_o = c_ctx_reg.in_x;
            d_data_next.beta_o  = beta_sat.value;
            d_data_next.clip    = beta_sat.clip;
        end else begin
            d_data_next.op_y    = c_ctx_reg.in_y;
            d_data_next.alpha_o = '0;
            d_data_next.beta_o  = '0;
            d_data_next.clip    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_ready) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg && d_ready) begin
            d_data_reg <= d_data_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

endmodule

### hdl/cpt_park_cell.sv
// ----------------------------------------------------------------------------
// cpt_park_cell
// park / inverse park products, rounding, saturation and output register
// ----------------------------------------------------------------------------
module cpt_park_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cpt_pkg::sine_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cpt_pkg::out_t    out_data
);

    logic                                   e_valid_reg;
    logic signed [cpt_pkg::PROD_W-1:0]      e_xc_reg;
    logic signed [cpt_pkg::PROD_W-1:0]      e_ys_reg;
    logic signed [cpt_pkg::PROD_W-1:0]      e_yc_reg;
    logic signed [cpt_pkg::PROD_W-1:0]      e_xs_reg;
    logic [1:0]                             e_mode_reg;
    logic signed [cpt_pkg::DATA_WIDTH-1:0]  e_alpha_reg;
    logic signed [cpt_pkg::DATA_WIDTH-1:0]  e_beta_reg;
    logic                                   e_clip_reg;
    logic                                   e_ready;

    logic                                   f_valid_reg;
    cpt_pkg::out_t                          f_data_reg;
    cpt_pkg::out_t                          f_data_next;
    logic                                   f_ready;
    logic signed [cpt_pkg::PROD_W:0]        sum_first;
    logic signed [cpt_pkg::PROD_W:0]        sum_second;
    cpt_pkg::sat_t                          sat_first;
    cpt_pkg::sat_t                          sat_second;

    assign e_ready  = !e_valid_reg || f_ready;
    assign f_ready  = !f_valid_reg || out_ready;
    assign in_ready = e_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_ready) begin
            e_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && e_ready) begin
            e_xc_reg    <= cpt_pkg::PROD_W'(in_data.op_x) * cpt_pkg::PROD_W'(in_data.cs);
            e_ys_reg    <= cpt_pkg::PROD_W'(in_data.op_y) * cpt_pkg::PROD_W'(in_data.sn);
            e_yc_reg    <= cpt_pkg::PROD_W'(in_data.op_y) * cpt_pkg::PROD_W'(in_data.cs);
            e_xs_reg    <= cpt_pkg::PROD_W'(in_data.op_x) * cpt_pkg::PROD_W'(in_data.sn);
            e_mode_reg  <= in_data.mode;
            e_alpha_reg <= in_data.alpha_o;
            e_beta_reg  <= in_data.beta_o;
            e_clip_reg  <= in_data.clip;
        end
    end

    always_comb begin
        if (e_mode_reg == cpt_pkg::MODE_INV_PARK) begin
            sum_first  = (cpt_pkg::PROD_W+1)'(e_xc_reg) - (cpt_pkg::PROD_W+1)'(e_ys_reg);
            sum_second = (cpt_pkg::PROD_W+1)'(e_yc_reg) + (cpt_pkg::PROD_W+1)'(e_xs_reg);
        end else begin
            sum_first  = (cpt_pkg::PROD_W+1)'(e_xc_reg) + (cpt_pkg::PROD_W+1)'(e_ys_reg);
            sum_second = (cpt_pkg::PROD_W+1)'(e_yc_reg) - (cpt_pkg::PROD_W+1)'(e_xs_reg);
        end
        sum_first  = sum_first  + ((cpt_pkg::PROD_W+1)'(1) <<< (cpt_pkg::SIN_FRAC - 1));
        sum_second = sum_second + ((cpt_pkg::PROD_W+1)'(1) <<< (cpt_pkg::SIN_FRAC - 1));
        sat_first  = cpt_pkg::saturate(sum_first[cpt_pkg::PROD_W:cpt_pkg::SIN_FRAC]);
        sat_second = cpt_pkg::saturate(sum_second[cpt_pkg::PROD_W:cpt_pkg::SIN_FRAC]);

        unique case (e_mode_reg)
            cpt_pkg::MODE_CLARKE_PARK, cpt_pkg::MODE_PARK, cpt_pkg::MODE_INV_PARK: begin
                f_data_next.out_first  = sat_first.value;
                f_data_next.out_second = sat_second.value;
                f_data_next.alpha_out  = e_alpha_reg;
                f_data_next.beta_out   = e_beta_reg;
                f_data_next.saturated  = sat_first.clip | sat_second.clip | e_clip_reg;
            end
            default: begin
                f_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_ready) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_valid_reg && f_ready) begin
            f_data_reg <= f_data_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_data  = f_data_reg;

endmodule

### hdl/clarke_park_transform.sv
// ----------------------------------------------------------------------------
// clarke_park_transform
// clarke / park / inverse park axis transform for field-oriented control
// ----------------------------------------------------------------------------
// s_ channel takes one item: mode, in_x, in_y (q1.15) and a rotor angle
// where a full turn is 2^16 counts. mode 0 runs clarke then park, mode 1
// park, mode 2 inverse park; mode 3 yields an all-zero result.
// m_ channel returns one result item per input item, in order, with the
// saturated flag set when any result was clipped to 16 bits.
// the datapath is a row of ten registered cells: angle fold, square,
// four horner steps of the sine polynomial, final product, rounding,
// park multiply and the sum / saturate stage that is the output register.
// one item per cycle is taken while m_ready stays high.
// each cell moves on when its neighbor has room, so when the receiver
// stalls the row fills its empty cells first and s_ready drops only when
// all ten cells hold an item.
// reset (aresetn low, synchronous) empties every cell; results of items
// in flight are dropped.
// ----------------------------------------------------------------------------
`include "clarke_park_transform_defines.svh"

module clarke_park_transform (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cpt_pkg::in_t     s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cpt_pkg::out_t    m_data
);

    logic            chain_valid [cpt_pkg::HORNER_STEPS+1];
    logic            chain_ready [cpt_pkg::HORNER_STEPS+1];
    cpt_pkg::poly_t  chain_data  [cpt_pkg::HORNER_STEPS+1];

    logic            sine_valid;
    logic            sine_ready;
    cpt_pkg::sine_t  sine_data;
    logic            sat_at_rail;

    cpt_front_cell u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar k = 0; k < cpt_pkg::HORNER_STEPS; k++) begin : g_horner
        cpt_horner_cell #(
            .COEF (cpt_pkg::HORNER_COEF[k])
        ) u_horner (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    cpt_back_cell u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[cpt_pkg::HORNER_STEPS]),
        .in_ready  (chain_ready[cpt_pkg::HORNER_STEPS]),
        .in_data   (chain_data[cpt_pkg::HORNER_STEPS]),
        .out_valid (sine_valid),
        .out_ready (sine_ready),
        .out_data  (sine_data)
    );

    cpt_park_cell u_park (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sine_valid),
        .in_ready  (sine_ready),
        .in_data   (sine_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // a clipped result always sits on one of the rails
    assign sat_at_rail = (m_data.out_first  == cpt_pkg::OUT_MAX)
                      || (m_data.out_first  == cpt_pkg::OUT_MIN)
                      || (m_data.out_second == cpt_pkg::OUT_MAX)
                      || (m_data.out_second == cpt_pkg::OUT_MIN)
                      || (m_data.beta_out   == cpt_pkg::OUT_MAX)
                      || (m_data.beta_out   == cpt_pkg::OUT_MIN);

    `CPT_ASSERT_IMPL(a_full_only_when_stalled, !s_ready, m_valid && !m_ready)
    `CPT_ASSERT_IMPL(a_flag_only_at_rail, m_valid && m_data.saturated, sat_at_rail)
    `CPT_ASSERT_RESET(a_empty_after_reset, !m_valid)

endmodule
